// File: rtl/acc_pkg.sv
// Shared types, constants and command codes of the adaptive cruise controller.
`timescale 1ns / 1ps
package acc_pkg;

	localparam int FracBits = 16;
	localparam int ErrW     = 26;
	localparam int IntW     = 48;
	localparam int DivW     = 44;
	localparam int OpAW     = 48;
	localparam int OpBW     = 17;
	localparam int ProdW    = OpAW + OpBW;
	localparam int AccW     = 60;

	localparam logic [1:0] MODE_SPEED = 2'd0;
	localparam logic [1:0] MODE_DIST  = 2'd1;
	localparam logic [1:0] MODE_STOP  = 2'd2;

	localparam logic [2:0] REG_GAP_SP  = 3'd0;
	localparam logic [2:0] REG_CRUISE  = 3'd1;
	localparam logic [2:0] REG_GAP_KP  = 3'd2;
	localparam logic [2:0] REG_GAP_KI  = 3'd3;
	localparam logic [2:0] REG_GAP_KD  = 3'd4;
	localparam logic [2:0] REG_SPD_KP  = 3'd5;
	localparam logic [2:0] REG_SPD_KI  = 3'd6;
	localparam logic [2:0] REG_SPD_KD  = 3'd7;

	// Multiply steps, issued in this order.
	localparam logic [2:0] MUL_GAP_INT = 3'd0;
	localparam logic [2:0] MUL_SPD_INT = 3'd1;
	localparam logic [2:0] MUL_GAP_P   = 3'd2;
	localparam logic [2:0] MUL_GAP_I   = 3'd3;
	localparam logic [2:0] MUL_SPD_P   = 3'd4;
	localparam logic [2:0] MUL_SPD_I   = 3'd5;
	localparam logic [2:0] MUL_GAP_D   = 3'd6;
	localparam logic [2:0] MUL_SPD_D   = 3'd7;

	localparam logic [23:0] DIST_HI    = 24'(55 << FracBits);
	localparam logic [23:0] DIST_LO    = 24'(45 << FracBits);
	localparam logic [21:0] CURVE_CAP  = 22'(15 << FracBits);
	localparam int          SlowSpeed  = 1 << (FracBits - 1);
	localparam int          AccelLim   = 20 << FracBits;
	localparam int          BrakeAccel = -(3 << FracBits);

	typedef struct packed {
		logic        target_present;
		logic [23:0] target_distance;
		logic        target_stopped;
		logic signed [23:0] ego_speed;
		logic        curved_lane;
		logic [15:0] tick_length;
	} in_item_t;

	typedef struct packed {
		logic signed [21:0] accel_command;
		logic [1:0]         active_mode;
	} out_item_t;

	typedef struct packed {
		logic       load;
		logic       err;
		logic       start;
		logic       mul_go;
		logic [2:0] mul_sel;
		logic       fin;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

endpackage

// File: rtl/adaptive_cruise_pid_controller_unit.sv
// Flow: input transfer, error and mode registers, divider start, wait on the bit-serial derivative dividers,
// multiply steps on the shared multiplier, drain, output register; no new tick is taken meanwhile.
// A new tick is taken as soon as the previous result sits in the output register.
// Reset clears loop integrals and previous errors, and loads the gain and setpoint defaults.
// Reset is asynchronous and active low; no clearing pass is needed.
`timescale 1ns / 1ps
module adaptive_cruise_pid_controller_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  acc_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output acc_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data
);
	import acc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	acc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	acc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_data(in_data), .cmd(cmd), .sts(sts), .out_data(out_data)
	);

`ifndef NO_ASSERTIONS
	// Stop mode always commands zero acceleration.
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.active_mode == MODE_STOP |-> out_data.accel_command == '0)
		else $error("stop mode with nonzero command");

	// The command never leaves the saturation band.
	a_lim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.accel_command <= 22'sd1310720 &&
			out_data.accel_command >= -22'sd1310720))
		else $error("command out of range");

	// After an input transfer the block is busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transfer accepted while busy");
`endif
endmodule

// File: rtl/acc_div.sv
// Bit-serial signed divider, truncating toward zero, one quotient bit per cycle.
`timescale 1ns / 1ps
module acc_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [acc_pkg::ErrW:0]   diff,
	input  logic [16:0]                     divisor,
	output logic                            busy,
	output logic signed [acc_pkg::DivW-1:0] quot
);
	import acc_pkg::*;

	localparam int NumW = ErrW + FracBits;
	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0] num_q;
	logic [17:0]     rem_q;
	logic [16:0]     dvs_q;
	logic            neg_q;
	logic [CntW-1:0] cnt_q;
	logic [17:0]     trial;
	logic [18:0]     sub;
	logic [ErrW:0]   mag;

	// Magnitude of the dividend before scaling.
	assign mag   = diff[ErrW] ? (ErrW + 1)'(-diff) : diff;
	assign trial = {rem_q[16:0], num_q[NumW-1]};
	assign sub   = {1'b0, trial} - {2'b0, dvs_q};

	// Control: iteration count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntW'(NumW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Restoring shift-subtract step.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {mag[NumW-FracBits-1:0], {FracBits{1'b0}}};
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= diff[ErrW];
		end else if (cnt_q != '0) begin
			if (!sub[18]) begin
				rem_q <= sub[17:0];
				num_q <= {num_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quot = neg_q ? -$signed({2'b0, num_q}) : $signed({2'b0, num_q});
endmodule

// File: rtl/acc_ctrl.sv
// Sequencer of the cruise controller: input transfer, division wait, multiply steps, result.
`timescale 1ns / 1ps
module acc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  acc_pkg::sts_t sts,
	output acc_pkg::cmd_t cmd
);
	import acc_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ERR   = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_MUL   = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] step_q;
	logic       ovld_q;
	logic       fin_ok;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = ovld_q;
	assign fin_ok    = (state_q == ST_FIN) && (!ovld_q || !out_stall);

	// Commands to the datapath.
	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == ST_IDLE) && in_valid;
		cmd.err     = (state_q == ST_ERR);
		cmd.start   = (state_q == ST_START);
		cmd.mul_go  = (state_q == ST_MUL);
		cmd.mul_sel = step_q;
		cmd.fin     = fin_ok;
	end

	// State transitions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE:  if (in_valid) state_q <= ST_ERR;
				ST_ERR:   state_q <= ST_START;
				ST_START: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (sts.div_done) begin
						state_q <= ST_MUL;
						step_q  <= '0;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == MUL_SPD_D) state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= ST_FIN;
				ST_FIN:   if (fin_ok) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (fin_ok) begin
			ovld_q <= 1'b1;
		end else if (!out_stall) begin
			ovld_q <= 1'b0;
		end
	end
endmodule

// File: rtl/acc_dp.sv
// Datapath: configuration registers, loop state, shared multiplier, dividers and result register.
`timescale 1ns / 1ps
module acc_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  acc_pkg::in_item_t  in_data,
	input  acc_pkg::cmd_t      cmd,
	output acc_pkg::sts_t      sts,
	output acc_pkg::out_item_t out_data
);
	import acc_pkg::*;

	logic [23:0] gap_sp_q;
	logic [21:0] cruise_q;
	logic [15:0] gkp_q, gki_q, gkd_q, skp_q, ski_q, skd_q;

	in_item_t item_q;
	logic signed [ErrW-1:0] gerr_q, serr_q, glast_q, slast_q;
	logic signed [IntW-1:0] gint_q, sint_q;
	logic signed [AccW-1:0] gacc_q, sacc_q;
	logic [1:0]             mode_q;
	logic                   slow_q;
	out_item_t              res_q;

	logic signed [OpAW-1:0]  op_a;
	logic [OpBW-1:0]         op_b;
	logic signed [ProdW-1:0] prod_s1;
	logic                    pv_s1;
	logic [2:0]              tag_s1;

	logic signed [DivW-1:0] gd, sd;
	logic                   gbusy, sbusy;
	logic [21:0]            sp;
	logic signed [ErrW-1:0] serr_n, gerr_n;
	logic signed [ProdW-1:0] sh16, sh8;
	logic signed [IntW:0]   isum;
	logic signed [IntW-1:0] iold, inew;
	logic signed [AccW-1:0] pick, lim;
	logic [1:0]             mode_n;
	logic                   slow_n;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_sp_q <= 24'd2621440;
			cruise_q <= 22'd1456210;
			gkp_q <= 16'd102;
			gki_q <= 16'd13;
			gkd_q <= 16'd26;
			skp_q <= 16'd128;
			ski_q <= 16'd26;
			skd_q <= 16'd13;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAP_SP: gap_sp_q <= cfg_data;
				REG_CRUISE: cruise_q <= cfg_data[21:0];
				REG_GAP_KP: gkp_q <= cfg_data[15:0];
				REG_GAP_KI: gki_q <= cfg_data[15:0];
				REG_GAP_KD: gkd_q <= cfg_data[15:0];
				REG_SPD_KP: skp_q <= cfg_data[15:0];
				REG_SPD_KI: ski_q <= cfg_data[15:0];
				REG_SPD_KD: skd_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Errors, mode and curve cap.
	always_comb begin
		sp = (item_q.curved_lane && cruise_q > CURVE_CAP) ? CURVE_CAP : cruise_q;
		gerr_n = $signed({2'b0, gap_sp_q}) - $signed({2'b0, item_q.target_distance});
		serr_n = $signed({4'b0, sp}) - ErrW'(item_q.ego_speed);
		slow_n = item_q.target_stopped && (item_q.ego_speed < 24'(SlowSpeed));
		if (!item_q.target_present || item_q.target_distance > DIST_HI) begin
			mode_n = MODE_SPEED;
		end else if (item_q.target_distance < DIST_LO) begin
			mode_n = MODE_DIST;
		end else begin
			mode_n = slow_n ? MODE_STOP : MODE_SPEED;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_data;
		if (cmd.err) begin
			gerr_q <= gerr_n;
			serr_q <= serr_n;
			mode_q <= mode_n;
			slow_q <= slow_n;
		end
	end

	// Previous errors and integrals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glast_q <= '0;
			slast_q <= '0;
			gint_q  <= '0;
			sint_q  <= '0;
		end else begin
			if (cmd.start) begin
				glast_q <= gerr_q;
				slast_q <= serr_q;
			end
			if (pv_s1 && tag_s1 == MUL_GAP_INT) gint_q <= inew;
			if (pv_s1 && tag_s1 == MUL_SPD_INT) sint_q <= inew;
		end
	end

	// Derivative dividers, one per loop.
	acc_div u_gdiv (
		.clk(clk), .arst_n(arst_n), .start(cmd.start),
		.diff((ErrW + 1)'(gerr_q) - (ErrW + 1)'(glast_q)),
		.divisor({1'b0, item_q.tick_length} + 17'd1),
		.busy(gbusy), .quot(gd)
	);
	acc_div u_sdiv (
		.clk(clk), .arst_n(arst_n), .start(cmd.start),
		.diff((ErrW + 1)'(serr_q) - (ErrW + 1)'(slast_q)),
		.divisor({1'b0, item_q.tick_length} + 17'd1),
		.busy(sbusy), .quot(sd)
	);
	assign sts.div_done = !gbusy && !sbusy;

	// Operand selection for the shared multiplier.
	always_comb begin
		case (cmd.mul_sel)
			MUL_GAP_INT: begin op_a = OpAW'(gerr_q); op_b = {1'b0, item_q.tick_length}; end
			MUL_SPD_INT: begin op_a = OpAW'(serr_q); op_b = {1'b0, item_q.tick_length}; end
			MUL_GAP_P:   begin op_a = OpAW'(gerr_q); op_b = {1'b0, gkp_q}; end
			MUL_GAP_I:   begin op_a = gint_q;        op_b = {1'b0, gki_q}; end
			MUL_SPD_P:   begin op_a = OpAW'(serr_q); op_b = {1'b0, skp_q}; end
			MUL_SPD_I:   begin op_a = sint_q;        op_b = {1'b0, ski_q}; end
			MUL_GAP_D:   begin op_a = OpAW'(gd);     op_b = {1'b0, gkd_q}; end
			MUL_SPD_D:   begin op_a = OpAW'(sd);     op_b = {1'b0, skd_q}; end
			default:     begin op_a = '0;            op_b = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= cmd.mul_go;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ProdW'(op_a) * $signed({{(ProdW-OpBW){1'b0}}, op_b});
		tag_s1  <= cmd.mul_sel;
	end

	// Integral update with saturation to the integral width.
	always_comb begin
		sh16 = prod_s1 >>> FracBits;
		sh8  = prod_s1 >>> 8;
		iold = (tag_s1 == MUL_GAP_INT) ? gint_q : sint_q;
		isum = (IntW + 1)'(iold) + (IntW + 1)'(sh16);
		if (isum[IntW] != isum[IntW-1]) begin
			inew = isum[IntW] ? {1'b1, {(IntW-1){1'b0}}} : {1'b0, {(IntW-1){1'b1}}};
		end else begin
			inew = isum[IntW-1:0];
		end
	end

	// Term accumulation.
	always_ff @(posedge clk) begin
		if (cmd.err) begin
			gacc_q <= '0;
			sacc_q <= '0;
		end else if (pv_s1) begin
			if (tag_s1 == MUL_GAP_P || tag_s1 == MUL_GAP_I || tag_s1 == MUL_GAP_D)
				gacc_q <= gacc_q + AccW'(sh8);
			if (tag_s1 == MUL_SPD_P || tag_s1 == MUL_SPD_I || tag_s1 == MUL_SPD_D)
				sacc_q <= sacc_q + AccW'(sh8);
		end
	end

	// Mode selection and output clamp.
	always_comb begin
		case (mode_q)
			MODE_SPEED: pick = sacc_q;
			MODE_DIST:  pick = slow_q ? AccW'(BrakeAccel) : gacc_q;
			default:    pick = '0;
		endcase
		if (pick > AccW'(AccelLim)) lim = AccW'(AccelLim);
		else if (pick < -AccW'(AccelLim)) lim = -AccW'(AccelLim);
		else lim = pick;
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			res_q.accel_command <= lim[21:0];
			res_q.active_mode   <= mode_q;
		end
	end

	assign out_data = res_q;
endmodule
